// ----- src/gtl_pkg.sv -----
package gtl_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int KIND_BITS       = 3;
  localparam int LINE_BITS       = 32;
  localparam int MAX_RESULTS     = 3;

  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [1:0]           count_t;

  localparam kind_t K_END    = 3'd0;
  localparam kind_t K_OPEN   = 3'd1;
  localparam kind_t K_CLOSE  = 3'd2;
  localparam kind_t K_INT    = 3'd3;
  localparam kind_t K_DOUBLE = 3'd4;
  localparam kind_t K_STRING = 3'd5;
  localparam kind_t K_ERROR  = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ----- src/gtl_core.sv -----
module gtl_core import gtl_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             text_byte,
  input  logic                   final_byte,
  output count_t                 grp_count,
  output kind_t                  grp_kind   [MAX_RESULTS],
  output logic [OFFSET_BITS-1:0] grp_offset [MAX_RESULTS],
  output logic [LENGTH_BITS-1:0] grp_length [MAX_RESULTS],
  output line_t                  grp_line   [MAX_RESULTS]
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_INT    = 3'd1;
  localparam logic [2:0] M_DOT    = 3'd2;
  localparam logic [2:0] M_DOUBLE = 3'd3;
  localparam logic [2:0] M_QUOTED = 3'd4;
  localparam logic [2:0] M_BARE   = 3'd5;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic [2:0]             lex_mode, lex_mode_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [LENGTH_BITS-1:0] run_length, run_length_next;
  line_t                  newline_count, newline_count_next;

  logic                   used;
  count_t                 n;
  logic [LENGTH_BITS:0]   sum1, sum2;
  logic [LENGTH_BITS-1:0] len_inc1, len_inc2;
  logic [OFFSET_BITS-1:0] pos_inc;

  assign sum1     = {1'b0, run_length} + (LENGTH_BITS + 1)'(1);
  assign sum2     = {1'b0, run_length} + (LENGTH_BITS + 1)'(2);
  assign len_inc1 = sum1[LENGTH_BITS] ? LEN_MAX : sum1[LENGTH_BITS-1:0];
  assign len_inc2 = sum2[LENGTH_BITS] ? LEN_MAX : sum2[LENGTH_BITS-1:0];
  assign pos_inc  = byte_position + OFFSET_BITS'(1);

  always_comb begin
    lex_mode_next      = lex_mode;
    start_offset_next  = start_offset;
    run_length_next    = run_length;
    newline_count_next = newline_count;
    byte_position_next = pos_inc;
    used = 1'b0;
    n    = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      grp_kind[i]   = K_END;
      grp_offset[i] = '0;
      grp_length[i] = '0;
      grp_line[i]   = newline_count;
    end

    // running token: extend it or close it
    unique case (lex_mode)
      M_INT: begin
        if (is_digit(text_byte) || text_byte == CH_MINUS) begin
          run_length_next = len_inc1;
          used = 1'b1;
        end else if (text_byte == CH_DOT) begin
          lex_mode_next = M_DOT;
          used = 1'b1;
        end else begin
          grp_kind[n] = K_INT; grp_offset[n] = start_offset; grp_length[n] = run_length;
          n = n + 2'd1;
        end
      end
      M_DOT: begin
        if (is_digit(text_byte) || text_byte == CH_E) begin
          run_length_next = len_inc2;
          lex_mode_next = M_DOUBLE;
          used = 1'b1;
        end else begin
          grp_kind[n] = K_ERROR; grp_offset[n] = start_offset; grp_length[n] = run_length;
          n = n + 2'd1;
        end
      end
      M_DOUBLE: begin
        if (is_digit(text_byte) || text_byte == CH_E || text_byte == CH_MINUS) begin
          run_length_next = len_inc1;
          used = 1'b1;
        end else begin
          grp_kind[n] = K_DOUBLE; grp_offset[n] = start_offset; grp_length[n] = run_length;
          n = n + 2'd1;
        end
      end
      M_QUOTED: begin
        if (text_byte == CH_QUOTE) begin
          grp_kind[n] = K_STRING; grp_offset[n] = start_offset; grp_length[n] = run_length;
          n = n + 2'd1;
          lex_mode_next = M_IDLE;
        end else begin
          run_length_next = len_inc1;
        end
        used = 1'b1;
      end
      M_BARE: begin
        if (!is_blank(text_byte)) begin
          run_length_next = len_inc1;
          used = 1'b1;
        end else begin
          grp_kind[n] = K_STRING; grp_offset[n] = start_offset; grp_length[n] = run_length;
          n = n + 2'd1;
        end
      end
      default: begin
      end
    endcase

    // byte not taken by a running token is lexed afresh
    if (!used) begin
      lex_mode_next = M_IDLE;
      if (is_blank(text_byte)) begin
        if (text_byte == CH_LF) newline_count_next = newline_count + LINE_BITS'(1);
      end else if (is_alpha(text_byte)) begin
        lex_mode_next = M_BARE;
        start_offset_next = byte_position;
        run_length_next = LENGTH_BITS'(1);
      end else if (is_digit(text_byte) || text_byte == CH_MINUS) begin
        lex_mode_next = M_INT;
        start_offset_next = byte_position;
        run_length_next = LENGTH_BITS'(1);
      end else if (text_byte == CH_QUOTE) begin
        lex_mode_next = M_QUOTED;
        start_offset_next = pos_inc;
        run_length_next = '0;
      end else begin
        if (text_byte == CH_OPEN) grp_kind[n] = K_OPEN;
        else if (text_byte == CH_CLOSE) grp_kind[n] = K_CLOSE;
        else grp_kind[n] = K_ERROR;
        grp_offset[n] = byte_position;
        grp_length[n] = LENGTH_BITS'(1);
        n = n + 2'd1;
      end
    end

    // end of buffer: close the running token, add the end token, restart
    if (final_byte) begin
      if (lex_mode_next != M_IDLE) begin
        unique case (lex_mode_next)
          M_INT:    grp_kind[n] = K_INT;
          M_DOUBLE: grp_kind[n] = K_DOUBLE;
          M_BARE:   grp_kind[n] = K_STRING;
          default:  grp_kind[n] = K_ERROR;
        endcase
        grp_offset[n] = start_offset_next;
        grp_length[n] = run_length_next;
        grp_line[n]   = newline_count_next;
        n = n + 2'd1;
      end
      grp_kind[n]   = K_END;
      grp_offset[n] = pos_inc;
      grp_length[n] = '0;
      grp_line[n]   = newline_count_next;
      n = n + 2'd1;
      lex_mode_next      = M_IDLE;
      start_offset_next  = '0;
      byte_position_next = '0;
      run_length_next    = '0;
      newline_count_next = '0;
    end
    grp_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= M_IDLE;
      start_offset  <= '0;
      byte_position <= '0;
      run_length    <= '0;
      newline_count <= '0;
    end else if (fire) begin
      lex_mode      <= lex_mode_next;
      start_offset  <= start_offset_next;
      byte_position <= byte_position_next;
      run_length    <= run_length_next;
      newline_count <= newline_count_next;
    end
  end

endmodule

// ----- src/gtl_emit.sv -----
module gtl_emit import gtl_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   grp_push,
  input  count_t                 grp_count,
  input  kind_t                  grp_kind   [MAX_RESULTS],
  input  logic [OFFSET_BITS-1:0] grp_offset [MAX_RESULTS],
  input  logic [LENGTH_BITS-1:0] grp_length [MAX_RESULTS],
  input  line_t                  grp_line   [MAX_RESULTS],
  output logic                   grp_ready,
  output logic                   token_valid,
  input  logic                   token_ready,
  output kind_t                  token_kind,
  output logic [OFFSET_BITS-1:0] token_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output line_t                  line_number,
  output logic                   run_last
);

  count_t                 cnt;
  kind_t                  kind   [MAX_RESULTS];
  logic [OFFSET_BITS-1:0] offset [MAX_RESULTS];
  logic [LENGTH_BITS-1:0] length [MAX_RESULTS];
  line_t                  line   [MAX_RESULTS];
  logic                   take;

  assign token_valid  = cnt != 2'd0;
  assign take         = token_valid && token_ready;
  assign run_last     = cnt == 2'd1;
  // a new group may load as the last pending token leaves
  assign grp_ready    = (cnt == 2'd0) || (run_last && token_ready);
  assign token_kind   = kind[0];
  assign token_offset = offset[0];
  assign token_length = length[0];
  assign line_number  = line[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (grp_push && grp_count != 2'd0) begin
      cnt <= grp_count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_push && grp_count != 2'd0) begin
      kind   <= grp_kind;
      offset <= grp_offset;
      length <= grp_length;
      line   <= grp_line;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        kind[i]   <= kind[i+1];
        offset[i] <= offset[i+1];
        length[i] <= length[i+1];
        line[i]   <= line[i+1];
      end
    end
  end

endmodule

// ----- src/gml_token_lexer.sv -----
// GML token lexer
// text channel: text_valid/text_ready carry one byte of the buffer per request,
// with final_byte high on the last byte of a buffer
// token channel: token_valid/token_ready carry one token per request (kind,
// offset, length, line count); run_last marks the last token caused by a byte
// a final byte closes any running token and adds an end token, and the next
// byte starts a new buffer at offset 0 with the line count at 0
// the first token of a byte is offered in the cycle after the byte is
// taken
// throughput: one byte per cycle while each byte gives at most one token and
// token_ready is high; a byte that gives k tokens (k up to 3) holds the text
// channel while its tokens drain from the token registers, one per ready cycle
// the next byte is taken in the same cycle as the last pending token leaves
// when the receiver stalls, text_ready drops until the pending tokens drain;
// no token is lost or repeated
// reset clears the lexer state and drops any pending tokens
module gml_token_lexer import gtl_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_ready,
  input  logic [7:0]             text_byte,
  input  logic                   final_byte,
  output logic                   token_valid,
  input  logic                   token_ready,
  output logic [2:0]             token_kind,
  output logic [OFFSET_BITS-1:0] token_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic [31:0]            line_number,
  output logic                   run_last
);

  logic                   fire;
  count_t                 grp_count;
  kind_t                  grp_kind   [MAX_RESULTS];
  logic [OFFSET_BITS-1:0] grp_offset [MAX_RESULTS];
  logic [LENGTH_BITS-1:0] grp_length [MAX_RESULTS];
  line_t                  grp_line   [MAX_RESULTS];
  logic                   grp_ready;

  assign text_ready = grp_ready;
  assign fire       = text_valid && grp_ready;

  gtl_core #(
    .LENGTH_BITS(LENGTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .grp_count  (grp_count),
    .grp_kind   (grp_kind),
    .grp_offset (grp_offset),
    .grp_length (grp_length),
    .grp_line   (grp_line)
  );

  gtl_emit #(
    .LENGTH_BITS(LENGTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .grp_push     (fire),
    .grp_count    (grp_count),
    .grp_kind     (grp_kind),
    .grp_offset   (grp_offset),
    .grp_length   (grp_length),
    .grp_line     (grp_line),
    .grp_ready    (grp_ready),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_offset (token_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .run_last     (run_last)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import gtl_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES   = 150;
  localparam int LONG_RUN       = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT,
    ST_DOT,
    ST_DOUBLE,
    ST_QUOTED,
    ST_BARE
  } lex_state_e;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] offset;
    logic [15:0] length;
    line_t       line;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        token_valid;
  logic        token_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [31:0] token_offset;
  logic [15:0] token_length;
  logic [31:0] line_number;
  logic        run_last;

  // lexer state mirrored by the predictor
  lex_state_e  mode_q;
  logic [31:0] start_q;
  logic [31:0] pos_q;
  logic [15:0] len_q;
  line_t       lines_q;

  token_t expected_tokens[$];
  token_t byte_tokens[$];

  int err_count   = 0;
  int quiet       = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  gml_token_lexer u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_offset (token_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .run_last     (run_last)
  );

  always #10 clk = ~clk;

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit space_ch(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [15:0] sat_len(input logic [15:0] a, input int unsigned inc);
    logic [31:0] s;
    s = a + inc;
    return (s > 32'h0000_ffff) ? 16'hffff : s[15:0];
  endfunction

  function automatic void clear_lexer();
    mode_q  = ST_IDLE;
    start_q = '0;
    pos_q   = '0;
    len_q   = '0;
    lines_q = '0;
  endfunction

  function automatic void issue(input kind_t k, input logic [31:0] off, input logic [15:0] len);
    token_t t;
    t.kind   = k;
    t.offset = off;
    t.length = len;
    t.line   = lines_q;
    t.last   = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void begin_run(input lex_state_e m, input logic [31:0] s,
                                    input logic [15:0] len);
    mode_q  = m;
    start_q = s;
    len_q   = len;
  endfunction

  // byte seen with no token running
  function automatic void lex_from_idle(input logic [7:0] c, input logic [31:0] p);
    if (space_ch(c)) begin
      if (c == CH_LF) lines_q = lines_q + 1;
    end else if (letter_ch(c)) begin
      begin_run(ST_BARE, p, 16'd1);
    end else if (digit_ch(c) || c == CH_MINUS) begin
      begin_run(ST_INT, p, 16'd1);
    end else if (c == CH_OPEN) begin
      issue(K_OPEN, p, 16'd1);
    end else if (c == CH_CLOSE) begin
      issue(K_CLOSE, p, 16'd1);
    end else if (c == CH_QUOTE) begin
      begin_run(ST_QUOTED, p + 1, 16'd0);
    end else begin
      issue(K_ERROR, p, 16'd1);
    end
  endfunction

  function automatic void lex_predict(input logic [7:0] c, input logic fin);
    logic [31:0] p;
    bit used;
    p    = pos_q;
    used = 1'b0;
    byte_tokens.delete();
    case (mode_q)
      ST_INT: begin
        if (digit_ch(c) || c == CH_MINUS) begin
          len_q = sat_len(len_q, 1);
          used  = 1'b1;
        end else if (c == CH_DOT) begin
          mode_q = ST_DOT;
          used   = 1'b1;
        end else begin
          issue(K_INT, start_q, len_q);
        end
      end
      ST_DOT: begin
        // the dot itself is counted once the fraction starts
        if (digit_ch(c) || c == CH_E) begin
          len_q  = sat_len(len_q, 2);
          mode_q = ST_DOUBLE;
          used   = 1'b1;
        end else begin
          issue(K_ERROR, start_q, len_q);
        end
      end
      ST_DOUBLE: begin
        if (digit_ch(c) || c == CH_E || c == CH_MINUS) begin
          len_q = sat_len(len_q, 1);
          used  = 1'b1;
        end else begin
          issue(K_DOUBLE, start_q, len_q);
        end
      end
      ST_QUOTED: begin
        if (c == CH_QUOTE) begin
          issue(K_STRING, start_q, len_q);
          mode_q = ST_IDLE;
        end else begin
          len_q = sat_len(len_q, 1);
        end
        used = 1'b1;
      end
      ST_BARE: begin
        if (!space_ch(c)) begin
          len_q = sat_len(len_q, 1);
          used  = 1'b1;
        end else begin
          issue(K_STRING, start_q, len_q);
        end
      end
      default: ;
    endcase
    if (!used) begin
      mode_q = ST_IDLE;
      lex_from_idle(c, p);
    end
    pos_q = p + 1;
    if (fin) begin
      case (mode_q)
        ST_INT:    issue(K_INT, start_q, len_q);
        ST_DOT:    issue(K_ERROR, start_q, len_q);
        ST_DOUBLE: issue(K_DOUBLE, start_q, len_q);
        ST_QUOTED: issue(K_ERROR, start_q, len_q);
        ST_BARE:   issue(K_STRING, start_q, len_q);
        default: ;
      endcase
      issue(K_END, pos_q, 16'd0);
      clear_lexer();
    end
    if (byte_tokens.size() > 0) byte_tokens[$].last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // sender in bursts; prediction runs at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
        @(negedge clk);
        text_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    text_valid <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (!text_ready);
    lex_predict(b, fin);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] digit_byte();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] letter_byte();
    return $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 25))
                                : 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] nonblank_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (space_ch(c));
    return c;
  endfunction

  function automatic logic [7:0] content_byte();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return CH_LF;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] number_byte();
    return ($urandom_range(0, 4) == 0) ? CH_MINUS : digit_byte();
  endfunction

  task automatic test_tokens();
    // brackets, bare string, double ended by a bracket, newline, quoted with tab
    send_text("[ab 1.5e-]\n\"c\td\"", 1'b1);
  endtask

  task automatic test_special();
    // stray bytes, two of them at the extremes of the byte range
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte("#", 1'b0);
    // dot followed by a letter, then an unterminated quote at the end
    send_text("7.x", 1'b0);
    send_text(" \"q", 1'b1);
    send_text("4.", 1'b1);
    // a byte that ends a token, opens another and closes the buffer
    send_text("-9[", 1'b1);
    send_text("\r", 1'b1);
  endtask

  task automatic test_long_token();
    sender_gaps = 1'b0;
    sink_stalls = 1'b1;
    send_byte(CH_QUOTE, 1'b0);
    for (int i = 0; i < LONG_RUN; i++) send_byte(content_byte(), 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    for (int i = 0; i < LONG_RUN; i++) send_byte(digit_byte(), i == LONG_RUN - 1);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random();
    logic [7:0] text_q[$];
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      text_q.delete();
      sender_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 15)) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          text_q.push_back(CH_OPEN);
        end else if (pick < 16) begin
          text_q.push_back(CH_CLOSE);
        end else if (pick < 30) begin
          n = $urandom_range(1, 6);
          repeat (n) text_q.push_back(number_byte());
        end else if (pick < 42) begin
          n = $urandom_range(1, 4);
          repeat (n) text_q.push_back(number_byte());
          text_q.push_back(CH_DOT);
          text_q.push_back($urandom_range(0, 3) == 0 ? CH_E : digit_byte());
          n = $urandom_range(0, 4);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: text_q.push_back(CH_E);
              1: text_q.push_back(CH_MINUS);
              default: text_q.push_back(digit_byte());
            endcase
          end
        end else if (pick < 56) begin
          text_q.push_back(CH_QUOTE);
          n = $urandom_range(0, 8);
          repeat (n) text_q.push_back(content_byte());
          text_q.push_back(CH_QUOTE);
        end else if (pick < 70) begin
          text_q.push_back(letter_byte());
          n = $urandom_range(0, 6);
          repeat (n) text_q.push_back(nonblank_byte());
        end else if (pick < 84) begin
          n = $urandom_range(1, 3);
          repeat (n) text_q.push_back(blank_byte());
        end else if (pick < 92) begin
          // broken double: dot then anything
          text_q.push_back(digit_byte());
          text_q.push_back(CH_DOT);
          text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        if (pick >= 16 && pick < 70 && $urandom_range(0, 9) < 7)
          text_q.push_back(blank_byte());
      end
      // now and then leave a quote open at the end of the buffer
      if ($urandom_range(0, 5) == 0) begin
        text_q.push_back(CH_QUOTE);
        n = $urandom_range(0, 4);
        repeat (n) text_q.push_back(content_byte());
      end
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      sent += text_q.size();
    end
  endtask

  // receiver stalls in short random stretches
  always @(negedge clk) begin
    if (!sink_stalls) begin
      token_ready <= 1'b1;
    end else if (stall_left > 0) begin
      token_ready <= 1'b0;
      stall_left--;
    end else begin
      token_ready <= 1'b1;
      if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && token_valid && token_ready) begin
      got = '{token_kind, token_offset, token_length, line_number, run_last};
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d offset %0d length %0d",
                                  got.kind, got.offset, got.length));
      end else begin
        want = expected_tokens.pop_front();
        if (got != want)
          report_mismatch($sformatf(
            "got kind %0d off %0d len %0d line %0d last %0b, want %0d %0d %0d %0d %0b",
            got.kind, got.offset, got.length, got.line, got.last,
            want.kind, want.offset, want.length, want.line, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((text_valid && text_ready) || (token_valid && token_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    clear_lexer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_tokens();
    test_special();
    test_long_token();
    test_random();
    @(negedge clk);
    text_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/gtl_pkg.sv
src/gtl_core.sv
src/gtl_emit.sv
src/gml_token_lexer.sv
tb/sv/tb_top.sv
